// ----- hdl/lru_handle_cache_defines.svh -----
// ----------------------------------------------------------------------------
// LRU handle cache assertion macros
// Shared concurrent assertion forms used by the cache RTL.
// ----------------------------------------------------------------------------
`ifndef LRU_HANDLE_CACHE_DEFINES_SVH
`define LRU_HANDLE_CACHE_DEFINES_SVH

// Check a condition at every clock edge outside reset.
`define LHC_ASSERT_ALWAYS(label, clk, rst, expr, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (expr)) else $error(msg);

// Check a consequence in the same cycle as its trigger.
`define LHC_ASSERT_IMPLY(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) else $error(msg);

// Check a consequence in the cycle after its trigger.
`define LHC_ASSERT_NEXT(label, clk, rst, pre, post, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) else $error(msg);

`endif

// ----- hdl/lhc_pkg.sv -----
// ----------------------------------------------------------------------------
// LRU handle cache package
// Widths, operation codes, sequencer states and cell control for the cache.
// ----------------------------------------------------------------------------
package lhc_pkg;

   // field widths of the channels
   localparam int OP_W        = 2;
   localparam int ID_W        = 32;
   localparam int CFG_W       = 8;
   localparam int RSP_SLOT_W  = 7;
   localparam int RSP_COUNT_W = 8;

   // default directory depth and limit after reset
   localparam int               CAPACITY_DEFAULT = 128;
   localparam logic [CFG_W-1:0] LIMIT_RESET      = 8'd100;

   // operation codes
   localparam logic [OP_W-1:0] OP_ACCESS = 2'd0;
   localparam logic [OP_W-1:0] OP_PEEK   = 2'd1;
   localparam logic [OP_W-1:0] OP_CLEAR  = 2'd2;

   // sequencer states
   typedef enum logic [1:0] {
      ST_IDLE,
      ST_LOOK,
      ST_FIND,
      ST_UPDATE
   } state_type;

   // control broadcast to every cell
   typedef struct packed {
      logic compare;
      logic update;
   } cell_ctrl_type;

endpackage

// ----- hdl/lhc_interfaces.sv -----
// ----------------------------------------------------------------------------
// LRU handle cache channels
// Valid/ready channels for requests, responses and the limit register.
// ----------------------------------------------------------------------------
interface lhc_req_if;
   import lhc_pkg::*;
   logic            valid;
   logic            ready;
   logic [OP_W-1:0] operation;
   logic [ID_W-1:0] object_id;

   modport source (output valid, output operation, output object_id, input ready);
   modport sink   (input valid, input operation, input object_id, output ready);
endinterface

interface lhc_rsp_if;
   import lhc_pkg::*;
   logic                   valid;
   logic                   ready;
   logic                   hit;
   logic [RSP_SLOT_W-1:0]  slot;
   logic                   evicted;
   logic [ID_W-1:0]        evicted_id;
   logic [RSP_COUNT_W-1:0] held_count;

   modport source (output valid, output hit, output slot, output evicted,
                   output evicted_id, output held_count, input ready);
   modport sink   (input valid, input hit, input slot, input evicted,
                   input evicted_id, input held_count, output ready);
endinterface

interface lhc_csr_if;
   import lhc_pkg::*;
   logic             valid;
   logic             ready;
   logic [CFG_W-1:0] data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

// ----- hdl/lhc_cell.sv -----
// ----------------------------------------------------------------------------
// LRU handle cache cell
// One recency position: holds an id and its slot, compares, shifts, loads.
// ----------------------------------------------------------------------------
module lhc_cell #(
   parameter int IDX    = 0,
   parameter int SLOT_W = 7,
   parameter int CNT_W  = 8
) (
   input  logic                  clock,
   input  lhc_pkg::cell_ctrl_type ctrl,
   input  logic [lhc_pkg::ID_W-1:0] key,
   input  logic [SLOT_W-1:0]     new_slot,
   input  logic [SLOT_W-1:0]     pos,
   input  logic [SLOT_W-1:0]     last,
   input  logic [CNT_W-1:0]      count,
   input  logic [lhc_pkg::ID_W-1:0] nbr_id,
   input  logic [SLOT_W-1:0]     nbr_slot,
   output logic [lhc_pkg::ID_W-1:0] id_out,
   output logic [SLOT_W-1:0]     slot_out,
   output logic                  match
);
   import lhc_pkg::*;

   localparam logic [CNT_W-1:0]  IDX_C = CNT_W'(IDX);
   localparam logic [SLOT_W-1:0] IDX_S = SLOT_W'(IDX);

   logic [ID_W-1:0]   id_ff;
   logic [SLOT_W-1:0] slot_ff;
   logic              match_ff;
   logic              shift_en;
   logic              load_en;

   // take the neighbor's entry inside the closing gap, load the new entry at its end
   assign shift_en = ctrl.update && (IDX_S >= pos) && (IDX_S < last);
   assign load_en  = ctrl.update && (IDX_S == last);

   // hold the entry, match only inside the live region
   always_ff @(posedge clock) begin
      if (ctrl.compare) begin
         match_ff <= (id_ff == key) && (IDX_C < count);
      end
      if (shift_en) begin
         id_ff   <= nbr_id;
         slot_ff <= nbr_slot;
      end else if (load_en) begin
         id_ff   <= key;
         slot_ff <= new_slot;
      end
   end

   assign id_out   = id_ff;
   assign slot_out = slot_ff;
   assign match    = match_ff;

endmodule

// ----- hdl/lhc_find.sv -----
// ----------------------------------------------------------------------------
// LRU handle cache match encoder
// Turns the cells' match flags into a hit, its position and its slot.
// ----------------------------------------------------------------------------
module lhc_find #(
   parameter int CAPACITY = 128,
   parameter int SLOT_W   = 7
) (
   input  logic [CAPACITY-1:0] match_vec,
   input  logic [SLOT_W-1:0]   slots [CAPACITY],
   output logic                found,
   output logic [SLOT_W-1:0]   found_pos,
   output logic [SLOT_W-1:0]   found_slot
);

   // lowest matching position and an and-or select of its slot
   always_comb begin
      found      = |match_vec;
      found_pos  = '0;
      found_slot = '0;
      for (int i = CAPACITY - 1; i >= 0; i--) begin
         if (match_vec[i]) begin
            found_pos = SLOT_W'(i);
         end
      end
      for (int i = 0; i < CAPACITY; i++) begin
         found_slot = found_slot | (slots[i] & {SLOT_W{match_vec[i]}});
      end
   end

endmodule

// ----- hdl/lru_handle_cache.sv -----
// ----------------------------------------------------------------------------
// LRU handle cache
// Fully associative least recently used directory of object ids.
// ----------------------------------------------------------------------------
// The directory is a row of CAPACITY cells ordered from least recent (cell 0)
// to most recent; each cell holds one id and its storage slot. One request is
// handled at a time: the accept beat, a compare in every cell, an encode and
// slot select over the match flags, and an update in which the response is
// written and, for an access, the cells close the gap by taking their upper
// neighbor's entry while the new entry loads at the top. The next request is
// taken the cycle after the response register is written; if a previous
// response is still unclaimed the update step waits for it. A storage slot is
// always one of 0 to count-1, so a new id gets slot count. The limit register
// may be written at any time and is always ready; zero acts as one and
// values above CAPACITY act as CAPACITY. No clearing pass follows reset.
// ----------------------------------------------------------------------------
`include "lru_handle_cache_defines.svh"

module lru_handle_cache #(
   parameter int CAPACITY = lhc_pkg::CAPACITY_DEFAULT
) (
   input  logic      clock,
   input  logic      reset,
   lhc_req_if.sink   req_port,
   lhc_rsp_if.source rsp_port,
   lhc_csr_if.sink   csr_port
);
   import lhc_pkg::*;

   localparam int SLOT_W = $clog2(CAPACITY);
   localparam int CNT_W  = $clog2(CAPACITY + 1);
   localparam int CMP_W  = (CNT_W > CFG_W) ? CNT_W : CFG_W;

   state_type         state_ff, state_in;
   logic [OP_W-1:0]   op_ff;
   logic [ID_W-1:0]   key_ff;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [CFG_W-1:0]  limit_ff;
   logic              hit_ff;
   logic [SLOT_W-1:0] hpos_ff;
   logic [SLOT_W-1:0] hslot_ff;

   logic                   rsp_valid_ff;
   logic                   rsp_hit_ff;
   logic [RSP_SLOT_W-1:0]  rsp_slot_ff;
   logic                   rsp_evicted_ff;
   logic [ID_W-1:0]        rsp_evicted_id_ff;
   logic [RSP_COUNT_W-1:0] rsp_held_count_ff;

   cell_ctrl_type     cell_ctrl;
   logic              rsp_load;
   logic              req_ready;

   logic [CAPACITY-1:0] match_vec;
   logic [ID_W-1:0]     cell_id   [CAPACITY];
   logic [SLOT_W-1:0]   cell_slot [CAPACITY];
   logic [ID_W-1:0]     nbr_id    [CAPACITY];
   logic [SLOT_W-1:0]   nbr_slot  [CAPACITY];

   logic              found;
   logic [SLOT_W-1:0] found_pos;
   logic [SLOT_W-1:0] found_slot;

   logic [CMP_W-1:0]  limit_eff;
   logic              evict;
   logic              drop;
   logic [SLOT_W-1:0] upd_pos;
   logic [SLOT_W-1:0] upd_last;
   logic [SLOT_W-1:0] upd_slot;
   logic              out_hit;
   logic [SLOT_W-1:0] out_slot;
   logic [ID_W-1:0]   out_evicted_id;

   // row of cells, each fed by its upper neighbor
   for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
      if (g < CAPACITY - 1) begin : g_link
         assign nbr_id[g]   = cell_id[g+1];
         assign nbr_slot[g] = cell_slot[g+1];
      end else begin : g_top
         assign nbr_id[g]   = '0;
         assign nbr_slot[g] = '0;
      end

      lhc_cell #(
         .IDX    (g),
         .SLOT_W (SLOT_W),
         .CNT_W  (CNT_W)
      ) u_cell (
         .clock    (clock),
         .ctrl     (cell_ctrl),
         .key      (key_ff),
         .new_slot (upd_slot),
         .pos      (upd_pos),
         .last     (upd_last),
         .count    (count_ff),
         .nbr_id   (nbr_id[g]),
         .nbr_slot (nbr_slot[g]),
         .id_out   (cell_id[g]),
         .slot_out (cell_slot[g]),
         .match    (match_vec[g])
      );
   end

   // encode the match flags
   lhc_find #(
      .CAPACITY (CAPACITY),
      .SLOT_W   (SLOT_W)
   ) u_find (
      .match_vec  (match_vec),
      .slots      (cell_slot),
      .found      (found),
      .found_pos  (found_pos),
      .found_slot (found_slot)
   );

   // clamp the limit into one to CAPACITY
   always_comb begin
      if (limit_ff == '0) begin
         limit_eff = CMP_W'(1);
      end else if (CMP_W'(limit_ff) > CMP_W'(CAPACITY)) begin
         limit_eff = CMP_W'(CAPACITY);
      end else begin
         limit_eff = CMP_W'(limit_ff);
      end
   end

   // decide eviction, the gap to close and the position of the new entry
   always_comb begin
      evict    = (op_ff == OP_ACCESS) && !hit_ff && (count_ff != '0)
                 && (CMP_W'(count_ff) >= limit_eff);
      drop     = hit_ff || evict;
      upd_last = drop ? SLOT_W'(count_ff - CNT_W'(1)) : SLOT_W'(count_ff);
      upd_pos  = hit_ff ? hpos_ff : (evict ? '0 : upd_last);
      upd_slot = hit_ff ? hslot_ff : (evict ? cell_slot[0] : count_ff[SLOT_W-1:0]);
   end

   // form the response fields and the next count
   always_comb begin
      out_hit        = 1'b0;
      out_slot       = '0;
      out_evicted_id = '0;
      count_in       = count_ff;
      case (op_ff)
         OP_ACCESS: begin
            out_hit  = hit_ff;
            out_slot = upd_slot;
            if (evict) begin
               out_evicted_id = cell_id[0];
            end
            if (!drop) begin
               count_in = count_ff + CNT_W'(1);
            end
         end
         OP_PEEK: begin
            out_hit  = hit_ff;
            out_slot = hit_ff ? hslot_ff : '0;
         end
         OP_CLEAR: begin
            count_in = '0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase
   end

   // sequencer: next state and strobes
   always_comb begin
      state_in  = state_ff;
      req_ready = 1'b0;
      cell_ctrl = '0;
      rsp_load  = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_port.valid) begin
               state_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            cell_ctrl.compare = 1'b1;
            state_in          = ST_FIND;
         end
         ST_FIND: begin
            state_in = ST_UPDATE;
         end
         ST_UPDATE: begin
            if (!rsp_valid_ff || rsp_port.ready) begin
               rsp_load         = 1'b1;
               cell_ctrl.update = (op_ff == OP_ACCESS);
               state_in         = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // state, count, limit and response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         limit_ff     <= LIMIT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (rsp_load) begin
            count_ff <= count_in;
         end
         if (csr_port.valid) begin
            limit_ff <= csr_port.data;
         end
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_port.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // capture the request beat, the encoded match and the response payload
   always_ff @(posedge clock) begin
      if (req_ready && req_port.valid) begin
         op_ff  <= req_port.operation;
         key_ff <= req_port.object_id;
      end
      if (state_ff == ST_FIND) begin
         hit_ff   <= found;
         hpos_ff  <= found_pos;
         hslot_ff <= found_slot;
      end
      if (rsp_load) begin
         rsp_hit_ff        <= out_hit;
         rsp_slot_ff       <= RSP_SLOT_W'(out_slot);
         rsp_evicted_ff    <= evict;
         rsp_evicted_id_ff <= out_evicted_id;
         rsp_held_count_ff <= RSP_COUNT_W'(count_in);
      end
   end

   assign req_port.ready      = req_ready;
   assign csr_port.ready      = 1'b1;
   assign rsp_port.valid      = rsp_valid_ff;
   assign rsp_port.hit        = rsp_hit_ff;
   assign rsp_port.slot       = rsp_slot_ff;
   assign rsp_port.evicted    = rsp_evicted_ff;
   assign rsp_port.evicted_id = rsp_evicted_id_ff;
   assign rsp_port.held_count = rsp_held_count_ff;

   // ids in the live region are unique, so at most one cell matches
   `LHC_ASSERT_IMPLY(a_single_match, clock, reset, state_ff == ST_FIND, $onehot0(match_vec), "more than one cell matched the id")
   // the count never runs past the row
   `LHC_ASSERT_ALWAYS(a_count_bound, clock, reset, count_ff <= CNT_W'(CAPACITY), "held count exceeds capacity")
   // an accepted beat starts the compare step
   `LHC_ASSERT_NEXT(a_accept_look, clock, reset, req_ready && req_port.valid, state_ff == ST_LOOK, "accepted beat did not start a lookup")
   // a written response is presented in the next cycle
   `LHC_ASSERT_NEXT(a_rsp_shown, clock, reset, rsp_load, rsp_valid_ff, "written response not presented")

endmodule

// ----- tb/tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// LRU handle cache testbench
// Drives lookups, peeks and clears through the request channel, predicts each
// response with a behavioral LRU directory, and compares every response beat
// field by field. The limit register is rewritten between phases while idle.
// ----------------------------------------------------------------------------
module tb;
   import lhc_pkg::*;

   localparam int          CAP        = CAPACITY_DEFAULT;
   localparam int          RUN_LIMIT  = 200000;
   localparam logic [1:0]  OP_UNUSED  = 2'd3;

   typedef struct packed {
      logic [OP_W-1:0] op;
      logic [ID_W-1:0] id;
   } lookup_req_type;

   typedef struct packed {
      logic                   hit;
      logic [RSP_SLOT_W-1:0]  slot;
      logic                   evicted;
      logic [ID_W-1:0]        evicted_id;
      logic [RSP_COUNT_W-1:0] held_count;
   } lookup_result_type;

   logic clock = 1'b0;
   logic reset;

   lhc_req_if req_bus ();
   lhc_rsp_if rsp_bus ();
   lhc_csr_if csr_bus ();

   lru_handle_cache #(.CAPACITY(CAP)) DUT (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_bus),
      .rsp_port (rsp_bus),
      .csr_port (csr_bus)
   );

   // behavioral directory: position 0 is least recent
   logic [ID_W-1:0]  dir_ids [CAP];
   int               dir_slots [CAP];
   int               dir_count = 0;
   logic [CFG_W-1:0] limit_reg = LIMIT_RESET;

   lookup_req_type      lookup_reqs [$];
   lookup_result_type   lookup_results [$];
   logic [ID_W-1:0]     recent_ids [$];
   lookup_req_type      next_req;
   lookup_result_type   want_rsp;

   int send_gap_pct = 31;
   int recv_gap_pct = 48;
   int req_beats    = 0;
   int hold_left    = 0;
   int cycle_count  = 0;
   int fail_count   = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // remove one directory entry and close the gap toward the least recent end
   function automatic void drop_entry(input int pos);
      int i;
      for (i = pos; i + 1 < dir_count; i++) begin
         dir_ids[i]   = dir_ids[i + 1];
         dir_slots[i] = dir_slots[i + 1];
      end
      dir_count--;
   endfunction

   // advance the directory by one request and return the response it causes
   function automatic lookup_result_type lru_lookup(input logic [OP_W-1:0] op,
                                                    input logic [ID_W-1:0] id);
      lookup_result_type r;
      int                pos;
      int                lim;
      int                new_slot;
      int                i;
      bit                used [CAP];
      r   = '0;
      pos = -1;
      for (i = 0; i < dir_count; i++) begin
         if (pos < 0 && dir_ids[i] == id) pos = i;
      end
      case (op)
         OP_CLEAR: begin
            dir_count = 0;
         end
         OP_PEEK: begin
            if (pos >= 0) begin
               r.hit  = 1'b1;
               r.slot = RSP_SLOT_W'(dir_slots[pos]);
            end
         end
         OP_ACCESS: begin
            lim = int'(limit_reg);
            if (lim < 1) lim = 1;
            if (lim > CAP) lim = CAP;
            if (pos >= 0) begin
               r.hit    = 1'b1;
               new_slot = dir_slots[pos];
               drop_entry(pos);
            end else if (dir_count >= lim && dir_count > 0) begin
               // full: reuse the least recent entry's slot
               r.evicted    = 1'b1;
               r.evicted_id = dir_ids[0];
               new_slot     = dir_slots[0];
               drop_entry(0);
            end else begin
               for (i = 0; i < CAP; i++) used[i] = 1'b0;
               for (i = 0; i < dir_count; i++) used[dir_slots[i]] = 1'b1;
               new_slot = 0;
               for (i = CAP - 1; i >= 0; i--) begin
                  if (!used[i]) new_slot = i;
               end
            end
            r.slot = RSP_SLOT_W'(new_slot);
            if (dir_count < CAP) begin
               dir_ids[dir_count]   = id;
               dir_slots[dir_count] = new_slot;
               dir_count++;
            end
         end
         default: ;
      endcase
      r.held_count = RSP_COUNT_W'(dir_count);
      return r;
   endfunction

   function automatic void check_field(input string name, input logic [ID_W-1:0] want,
                                       input logic [ID_W-1:0] got);
      if (want !== got) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         fail_count++;
      end
   endfunction

   // request driver: predict on each accepted beat, then offer the next item
   always @(posedge clock) begin
      if (reset) begin
         req_bus.valid <= 1'b0;
      end else begin
         if (req_bus.valid && req_bus.ready) begin
            lookup_results = {lookup_results,
                              lru_lookup(req_bus.operation, req_bus.object_id)};
            req_beats <= req_beats + 1;
         end
         if (!req_bus.valid || req_bus.ready) begin
            if (lookup_reqs.size() != 0 && $urandom_range(99) >= send_gap_pct) begin
               next_req = lookup_reqs[0];
               lookup_reqs.delete(0);
               req_bus.valid     <= 1'b1;
               req_bus.operation <= next_req.op;
               req_bus.object_id <= next_req.id;
            end else begin
               req_bus.valid <= 1'b0;
            end
         end
      end
   end

   // long receiver hold-off so the block backs up and stalls its input
   always @(posedge clock) begin
      if (reset) begin
         hold_left <= 0;
      end else if (hold_left != 0) begin
         hold_left <= hold_left - 1;
      end else if (req_bus.valid && req_bus.ready &&
                   (req_beats == 60 || req_beats == 400 || $urandom_range(199) == 0)) begin
         hold_left <= $urandom_range(40, 90);
      end
   end

   // response monitor: check each beat against the oldest prediction
   always @(posedge clock) begin
      if (reset) begin
         rsp_bus.ready <= 1'b0;
      end else begin
         if (rsp_bus.valid && rsp_bus.ready) begin
            if (lookup_results.size() == 0) begin
               $error("response beat with no lookup outstanding");
               fail_count++;
            end else begin
               want_rsp = lookup_results[0];
               lookup_results.delete(0);
               check_field("hit", ID_W'(want_rsp.hit), ID_W'(rsp_bus.hit));
               check_field("slot", ID_W'(want_rsp.slot), ID_W'(rsp_bus.slot));
               check_field("evicted", ID_W'(want_rsp.evicted), ID_W'(rsp_bus.evicted));
               check_field("evicted_id", want_rsp.evicted_id, rsp_bus.evicted_id);
               check_field("held_count", ID_W'(want_rsp.held_count),
                           ID_W'(rsp_bus.held_count));
            end
         end
         rsp_bus.ready <= (hold_left == 0) && ($urandom_range(99) >= recv_gap_pct);
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= RUN_LIMIT) begin
         $display("lru_handle_cache: mismatch");
         $finish;
      end
   end

   task automatic queue_req(input logic [OP_W-1:0] op, input logic [ID_W-1:0] id);
      lookup_req_type item;
      item.op = op;
      item.id = id;
      lookup_reqs = {lookup_reqs, item};
   endtask

   // hold until every item is sent and every response has come back
   task automatic wait_drained();
      while (lookup_reqs.size() != 0 || lookup_results.size() != 0 || req_bus.valid)
         @(posedge clock);
   endtask

   task automatic write_limit(input logic [CFG_W-1:0] value);
      @(posedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.data  <= value;
      do @(posedge clock); while (!csr_bus.ready);
      limit_reg = value;
      csr_bus.valid <= 1'b0;
   endtask

   // random phase: mostly accesses over a window of recent ids, plus noise
   task automatic run_random(input logic [CFG_W-1:0] lim, input int count,
                             input int fresh_pct, input int acc_pct,
                             input int peek_pct, input int clear_pct);
      int              n;
      int              pick;
      logic [ID_W-1:0] id;
      logic [OP_W-1:0] op;
      write_limit(lim);
      for (n = 0; n < count; n++) begin
         if (recent_ids.size() == 0 || $urandom_range(99) < fresh_pct) begin
            id = $urandom;
            recent_ids = {recent_ids, id};
            if (recent_ids.size() > 160) recent_ids.delete(0);
         end else begin
            id = recent_ids[$urandom_range(recent_ids.size() - 1)];
         end
         pick = $urandom_range(99);
         if (pick < acc_pct) op = OP_ACCESS;
         else if (pick < acc_pct + peek_pct) op = OP_PEEK;
         else if (pick < acc_pct + peek_pct + clear_pct) op = OP_CLEAR;
         else op = OP_UNUSED;
         queue_req(op, id);
      end
      wait_drained();
   endtask

   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.operation = OP_ACCESS;
      req_bus.object_id = '0;
      rsp_bus.ready     = 1'b0;
      csr_bus.valid     = 1'b0;
      csr_bus.data      = '0;
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      // reset limit: misses, hits, peeks, unused code, clear
      queue_req(OP_ACCESS, 32'h0000_0000);
      queue_req(OP_ACCESS, 32'hFFFF_FFFF);
      queue_req(OP_ACCESS, 32'h0000_0000);
      queue_req(OP_PEEK,   32'hFFFF_FFFF);
      queue_req(OP_PEEK,   32'h1234_5678);
      queue_req(OP_UNUSED, 32'hA5A5_A5A5);
      queue_req(OP_CLEAR,  32'h5A5A_5A5A);
      queue_req(OP_PEEK,   32'h0000_0000);
      wait_drained();

      // single entry: each new id after the first evicts the one before it
      write_limit(8'd1);
      queue_req(OP_ACCESS, 32'h1111_1111);
      queue_req(OP_ACCESS, 32'h2222_2222);
      queue_req(OP_ACCESS, 32'h2222_2222);
      wait_drained();

      // zero limit behaves as one
      write_limit(8'd0);
      queue_req(OP_ACCESS, 32'h3333_3333);
      wait_drained();

      // fill four, then lower the limit below the count
      write_limit(8'd4);
      queue_req(OP_ACCESS, 32'h0000_0001);
      queue_req(OP_ACCESS, 32'h0000_0002);
      queue_req(OP_ACCESS, 32'h0000_0003);
      queue_req(OP_ACCESS, 32'h0000_0004);
      wait_drained();
      write_limit(8'd2);
      queue_req(OP_ACCESS, 32'h0000_0005);
      queue_req(OP_ACCESS, 32'h0000_0003);
      queue_req(OP_CLEAR,  32'h0000_0000);
      wait_drained();

      // small limit with heavy eviction, then fill to full capacity
      run_random(8'd3, 60, 40, 65, 25, 5);
      run_random(8'd255, 200, 75, 92, 6, 0);

      send_gap_pct = 48;
      recv_gap_pct = 31;
      // limit far below the held count, then the nominal top
      run_random(8'd16, 80, 40, 70, 22, 4);
      run_random(8'd128, 100, 30, 65, 25, 5);

      send_gap_pct = 0;
      recv_gap_pct = 0;
      run_random(8'd1, 40, 50, 65, 25, 5);
      run_random(LIMIT_RESET, 80, 35, 65, 25, 5);

      repeat (12) @(posedge clock);
      if (fail_count == 0) begin
         $display("lru_handle_cache: match");
      end else begin
         $display("lru_handle_cache: mismatch");
      end
      $finish;
   end

endmodule

// ----- filelist.f -----
+incdir+hdl
hdl/lhc_pkg.sv
hdl/lhc_interfaces.sv
hdl/lhc_cell.sv
hdl/lhc_find.sv
hdl/lru_handle_cache.sv
tb/tb.sv
